// ----- hdl/sbck_pkg.sv -----
// sbck_pkg: shared types and constants for the sprite blit with color key
// field widths, register indexes, reset values of the configuration registers
// no dependencies
package sbck_pkg;

    localparam int MaxSpriteSide = 1024;
    localparam int BytesPerPixel = 4;

    localparam int PixelW   = 32;
    localparam int CoordW   = 14;
    localparam int OffsetW  = 28;
    localparam int BgIndexW = 26;

    localparam int PitchW   = 15;
    localparam int SideCfgW = 11;
    localparam int CenterW  = 12;
    localparam int BgWidthW = 13;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 15;

    localparam int InDataW  = 64;
    localparam int OutDataW = 120;

    localparam logic [PitchW-1:0]   PitchReset   = PitchW'(4096);
    localparam logic [SideCfgW-1:0] SideReset    = SideCfgW'(1);
    localparam logic [BgWidthW-1:0] BgWidthReset = BgWidthW'(1024);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LINE_PITCH    = 3'd0,
        CFG_SPRITE_WIDTH  = 3'd1,
        CFG_SPRITE_HEIGHT = 3'd2,
        CFG_CENTER_X      = 3'd3,
        CFG_CENTER_Y      = 3'd4,
        CFG_ERASE_MODE    = 3'd5,
        CFG_BG_WIDTH      = 3'd6
    } cfg_index_t;

endpackage

// ----- hdl/sprite_blit_color_key.sv -----
// sprite_blit_color_key: two-stage register pipeline, one pixel per cycle unless
// m_axis_tready stalls the output; an input beat passes the input stage, then the
// output stage (position counters feed the input stage, row multipliers the output stage)
// rst_n clears the pipeline valids and the counters asynchronously and loads
// the configuration registers with their reset values
// depends on sbck_pkg
module sprite_blit_color_key
    import sbck_pkg::*;
#(
    parameter int MaxSide = MaxSpriteSide
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // sprite_pixel, background_pixel
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // write_offset, write_data, pixel_x,
                                                // pixel_y, background_index, zero pad
    output logic                m_axis_tuser,   // write_enable
    output logic                m_axis_tlast
);

    localparam int CW = (MaxSide > 1) ? $clog2(MaxSide) : 1;
    localparam int SW = CW + 1;

    logic [PitchW-1:0]   pitch_reg;
    logic [SideCfgW-1:0] width_reg;
    logic [SideCfgW-1:0] height_reg;
    logic [CenterW-1:0]  cx_reg;
    logic [CenterW-1:0]  cy_reg;
    logic                erase_reg;
    logic [BgWidthW-1:0] bgw_reg;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;

    logic                     s1_valid_reg;
    logic [PixelW-1:0]        s1_data_reg;
    logic                     s1_we_reg;
    logic                     s1_last_reg;
    logic signed [CoordW-1:0] s1_x_reg;
    logic signed [CoordW-1:0] s1_y_reg;

    logic                       m_valid_reg;
    logic [OffsetW-1:0]         m_off_reg;
    logic [PixelW-1:0]          m_data_reg;
    logic                       m_we_reg;
    logic                       m_last_reg;
    logic [CoordW-1:0]          m_x_reg;
    logic [CoordW-1:0]          m_y_reg;
    logic [BgIndexW-1:0]        m_bg_reg;

    logic [SW-1:0] w_clamp;
    logic [SW-1:0] h_clamp;
    logic          end_col;
    logic          end_row;
    logic          in_fire;
    logic          s1_adv;
    logic [PixelW-1:0] spr_pix;
    logic [PixelW-1:0] bck_pix;
    logic signed [CoordW-1:0] x_cur;
    logic signed [CoordW-1:0] y_cur;
    logic signed [OffsetW-1:0] off_full;
    logic signed [BgIndexW-1:0] bg_full;

    function automatic logic [SW-1:0] side_clamp(input logic [SideCfgW-1:0] v);
        logic [SW-1:0] r;
        if (v == '0)
        begin
            r = SW'(1);
        end
        else if (13'(v) > 13'(MaxSide))
        begin
            r = SW'(MaxSide);
        end
        else
        begin
            r = SW'(v);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    assign spr_pix = s_axis_tdata[PixelW-1:0];
    assign bck_pix = s_axis_tdata[2*PixelW-1:PixelW];

    assign w_clamp = side_clamp(width_reg);
    assign h_clamp = side_clamp(height_reg);
    assign end_col = {1'b0, col_reg} >= (w_clamp - SW'(1));
    assign end_row = {1'b0, row_reg} >= (h_clamp - SW'(1));

    assign x_cur = $signed(CoordW'(cx_reg) - CoordW'(w_clamp >> 1) + CoordW'(col_reg));
    assign y_cur = $signed(CoordW'(cy_reg) - CoordW'(h_clamp >> 1) + CoordW'(row_reg));

    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign off_full = s1_y_reg * $signed({1'b0, pitch_reg})
                    + s1_x_reg * $signed(OffsetW'(BytesPerPixel));
    assign bg_full  = s1_y_reg * $signed({1'b0, bgw_reg}) + s1_x_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= PitchReset;
            width_reg  <= SideReset;
            height_reg <= SideReset;
            cx_reg     <= '0;
            cy_reg     <= '0;
            erase_reg  <= 1'b0;
            bgw_reg    <= BgWidthReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINE_PITCH:    pitch_reg  <= cfg_data[PitchW-1:0];
                CFG_SPRITE_WIDTH:  width_reg  <= cfg_data[SideCfgW-1:0];
                CFG_SPRITE_HEIGHT: height_reg <= cfg_data[SideCfgW-1:0];
                CFG_CENTER_X:      cx_reg     <= cfg_data[CenterW-1:0];
                CFG_CENTER_Y:      cy_reg     <= cfg_data[CenterW-1:0];
                CFG_ERASE_MODE:    erase_reg  <= cfg_data[0];
                CFG_BG_WIDTH:      bgw_reg    <= cfg_data[BgWidthW-1:0];
                default:           ;
            endcase
        end
    end

    // raster position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (end_col)
            begin
                col_reg <= '0;
                row_reg <= end_row ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= erase_reg ? bck_pix : spr_pix;
            s1_we_reg   <= spr_pix != '0;
            s1_last_reg <= end_col && end_row;
            s1_x_reg    <= x_cur;
            s1_y_reg    <= y_cur;
        end
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (!m_valid_reg || m_axis_tready)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            m_off_reg  <= off_full;
            m_data_reg <= s1_data_reg;
            m_we_reg   <= s1_we_reg;
            m_last_reg <= s1_last_reg;
            m_x_reg    <= s1_x_reg;
            m_y_reg    <= s1_y_reg;
            m_bg_reg   <= bg_full;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_we_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {
        (OutDataW-OffsetW-PixelW-2*CoordW-BgIndexW)'(0),
        m_bg_reg, m_y_reg, m_x_reg, m_data_reg, m_off_reg
    };

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_col) |=> (col_reg == '0))
        else $error("column counter did not wrap at end of row");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !end_col) |=> (col_reg == $past(col_reg) + CW'(1)))
        else $error("column counter did not advance");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(row_reg))
        else $error("row counter moved without an input beat");

    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_valid_reg && !s1_valid_reg) |=> !m_valid_reg)
        else $error("output beat appeared with empty pipeline");
`endif

endmodule
